>>> src/fcpf_pkg.sv
// ----------------------------------------------------------------------------
// fcpf_pkg: shared definitions of the foot contact probability filter
// Widths, register indexes, reset values, the control word layout and the
// step addresses of the control program.
// ----------------------------------------------------------------------------
package fcpf_pkg;

  localparam int NUM_LEGS   = 4;
  localparam int LEG_W      = 2;
  localparam int FORCE_W    = 20;
  localparam int PROB_W     = 16;
  localparam int SQ_W       = 2 * FORCE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int STEP_W     = 5;
  localparam int CNT_W      = 5;

  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(FORCE_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(PROB_W - 1);
  localparam logic [SQ_W-1:0]  SQRT_BIT_INIT = {2'b01, {(SQ_W - 2){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_FORCE_LOW_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_HIGH_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_LOW         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_HIGH        = 3'd3;

  localparam logic [FORCE_W-1:0] RESET_FORCE_LOW_LIMIT  = 20'd160;
  localparam logic [FORCE_W-1:0] RESET_FORCE_HIGH_LIMIT = 20'd400;
  localparam logic [PROB_W-1:0]  RESET_PROB_LOW         = 16'd655;
  localparam logic [PROB_W-1:0]  RESET_PROB_HIGH        = 16'd64881;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ABS,
    OP_MUL_X,
    OP_MUL_Y,
    OP_MUL_Z,
    OP_ADD_Z,
    OP_SQRT_INIT,
    OP_SQRT_ITER,
    OP_INTERP_SETUP,
    OP_MUL_D,
    OP_DIV_INIT,
    OP_DIV_ITER,
    OP_RAW_INTERP,
    OP_RAW_LOW,
    OP_RAW_HIGH,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_IN,
    COND_Z_POS,
    COND_LOOP_MORE,
    COND_M_LT_LO,
    COND_M_GE_HI,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic no_in;
    logic z_pos;
    logic loop_more;
    logic m_lt_lo;
    logic m_ge_hi;
    logic out_busy;
  } status_t;

  localparam logic [STEP_W-1:0] STEP_IDLE      = 5'd0;
  localparam logic [STEP_W-1:0] STEP_ABS       = 5'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_X     = 5'd2;
  localparam logic [STEP_W-1:0] STEP_MUL_Y     = 5'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_Z     = 5'd4;
  localparam logic [STEP_W-1:0] STEP_ADD_Z     = 5'd5;
  localparam logic [STEP_W-1:0] STEP_SQRT_INIT = 5'd6;
  localparam logic [STEP_W-1:0] STEP_SQRT_ITER = 5'd7;
  localparam logic [STEP_W-1:0] STEP_CMP_LO    = 5'd8;
  localparam logic [STEP_W-1:0] STEP_CMP_HI    = 5'd9;
  localparam logic [STEP_W-1:0] STEP_SETUP     = 5'd10;
  localparam logic [STEP_W-1:0] STEP_MUL_D     = 5'd11;
  localparam logic [STEP_W-1:0] STEP_DIV_INIT  = 5'd12;
  localparam logic [STEP_W-1:0] STEP_DIV_ITER  = 5'd13;
  localparam logic [STEP_W-1:0] STEP_RAW_INT   = 5'd14;
  localparam logic [STEP_W-1:0] STEP_RAW_LOW   = 5'd15;
  localparam logic [STEP_W-1:0] STEP_RAW_HIGH  = 5'd16;
  localparam logic [STEP_W-1:0] STEP_EMIT      = 5'd17;
  localparam logic [STEP_W-1:0] STEP_RETURN    = 5'd18;

endpackage

>>> src/fcpf_ucode_rom.sv
// ----------------------------------------------------------------------------
// fcpf_ucode_rom: control program of the filter
// One control word per step: a datapath operation, a jump condition and a
// jump target. Without a taken jump the sequencer moves to the next step.
// ----------------------------------------------------------------------------
module fcpf_ucode_rom (
  input  logic [fcpf_pkg::STEP_W-1:0] step,
  output fcpf_pkg::ucode_t            word
);

  always_comb begin
    unique case (step)
      fcpf_pkg::STEP_IDLE:
        word = '{fcpf_pkg::OP_LOAD, fcpf_pkg::COND_NO_IN, fcpf_pkg::STEP_IDLE};
      fcpf_pkg::STEP_ABS:
        word = '{fcpf_pkg::OP_ABS, fcpf_pkg::COND_Z_POS, fcpf_pkg::STEP_RAW_LOW};
      fcpf_pkg::STEP_MUL_X:
        word = '{fcpf_pkg::OP_MUL_X, fcpf_pkg::COND_NONE, fcpf_pkg::STEP_IDLE};
      fcpf_pkg::STEP_MUL_Y:
        word = '{fcpf_pkg::OP_MUL_Y, fcpf_pkg::COND_NONE, fcpf_pkg::STEP_IDLE};
      fcpf_pkg::STEP_MUL_Z:
        word = '{fcpf_pkg::OP_MUL_Z, fcpf_pkg::COND_NONE, fcpf_pkg::STEP_IDLE};
      fcpf_pkg::STEP_ADD_Z:
        word = '{fcpf_pkg::OP_ADD_Z, fcpf_pkg::COND_NONE, fcpf_pkg::STEP_IDLE};
      fcpf_pkg::STEP_SQRT_INIT:
        word = '{fcpf_pkg::OP_SQRT_INIT, fcpf_pkg::COND_NONE, fcpf_pkg::STEP_IDLE};
      fcpf_pkg::STEP_SQRT_ITER:
        word = '{fcpf_pkg::OP_SQRT_ITER, fcpf_pkg::COND_LOOP_MORE,
                 fcpf_pkg::STEP_SQRT_ITER};
      fcpf_pkg::STEP_CMP_LO:
        word = '{fcpf_pkg::OP_NONE, fcpf_pkg::COND_M_LT_LO, fcpf_pkg::STEP_RAW_LOW};
      fcpf_pkg::STEP_CMP_HI:
        word = '{fcpf_pkg::OP_NONE, fcpf_pkg::COND_M_GE_HI, fcpf_pkg::STEP_RAW_HIGH};
      fcpf_pkg::STEP_SETUP:
        word = '{fcpf_pkg::OP_INTERP_SETUP, fcpf_pkg::COND_NONE, fcpf_pkg::STEP_IDLE};
      fcpf_pkg::STEP_MUL_D:
        word = '{fcpf_pkg::OP_MUL_D, fcpf_pkg::COND_NONE, fcpf_pkg::STEP_IDLE};
      fcpf_pkg::STEP_DIV_INIT:
        word = '{fcpf_pkg::OP_DIV_INIT, fcpf_pkg::COND_NONE, fcpf_pkg::STEP_IDLE};
      fcpf_pkg::STEP_DIV_ITER:
        word = '{fcpf_pkg::OP_DIV_ITER, fcpf_pkg::COND_LOOP_MORE,
                 fcpf_pkg::STEP_DIV_ITER};
      fcpf_pkg::STEP_RAW_INT:
        word = '{fcpf_pkg::OP_RAW_INTERP, fcpf_pkg::COND_ALWAYS, fcpf_pkg::STEP_EMIT};
      fcpf_pkg::STEP_RAW_LOW:
        word = '{fcpf_pkg::OP_RAW_LOW, fcpf_pkg::COND_ALWAYS, fcpf_pkg::STEP_EMIT};
      fcpf_pkg::STEP_RAW_HIGH:
        word = '{fcpf_pkg::OP_RAW_HIGH, fcpf_pkg::COND_NONE, fcpf_pkg::STEP_IDLE};
      fcpf_pkg::STEP_EMIT:
        word = '{fcpf_pkg::OP_EMIT, fcpf_pkg::COND_OUT_BUSY, fcpf_pkg::STEP_EMIT};
      fcpf_pkg::STEP_RETURN:
        word = '{fcpf_pkg::OP_NONE, fcpf_pkg::COND_ALWAYS, fcpf_pkg::STEP_IDLE};
      default:
        word = '{fcpf_pkg::OP_NONE, fcpf_pkg::COND_ALWAYS, fcpf_pkg::STEP_IDLE};
    endcase
  end

endmodule

>>> src/fcpf_sequencer.sv
// ----------------------------------------------------------------------------
// fcpf_sequencer: step counter of the control program
// Holds the current step, reads its control word and takes the jump when
// the selected datapath condition is true.
// ----------------------------------------------------------------------------
module fcpf_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  fcpf_pkg::status_t  status,
  output fcpf_pkg::ucode_t   ctrl
);

  logic [fcpf_pkg::STEP_W-1:0] step;
  logic [fcpf_pkg::STEP_W-1:0] step_next;
  logic                        jump;

  fcpf_ucode_rom u_rom (
    .step (step),
    .word (ctrl)
  );

  always_comb begin
    unique case (ctrl.cond)
      fcpf_pkg::COND_NONE:      jump = 1'b0;
      fcpf_pkg::COND_ALWAYS:    jump = 1'b1;
      fcpf_pkg::COND_NO_IN:     jump = status.no_in;
      fcpf_pkg::COND_Z_POS:     jump = status.z_pos;
      fcpf_pkg::COND_LOOP_MORE: jump = status.loop_more;
      fcpf_pkg::COND_M_LT_LO:   jump = status.m_lt_lo;
      fcpf_pkg::COND_M_GE_HI:   jump = status.m_ge_hi;
      fcpf_pkg::COND_OUT_BUSY:  jump = status.out_busy;
      default:                  jump = 1'b1;
    endcase
    step_next = jump ? ctrl.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= fcpf_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

>>> src/fcpf_datapath.sv
// ----------------------------------------------------------------------------
// fcpf_datapath: arithmetic and storage of the filter
// Input capture, shared multiplier, bit-serial square root, restoring
// divider, per-leg probability store, configuration and output registers.
// ----------------------------------------------------------------------------
module fcpf_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  fcpf_pkg::ucode_t                      ctrl,
  output fcpf_pkg::status_t                     status,
  input  logic                                  in_valid,
  input  logic [fcpf_pkg::LEG_W-1:0]            leg,
  input  logic signed [fcpf_pkg::FORCE_W-1:0]   force_x,
  input  logic signed [fcpf_pkg::FORCE_W-1:0]   force_y,
  input  logic signed [fcpf_pkg::FORCE_W-1:0]   force_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [fcpf_pkg::LEG_W-1:0]            leg_out,
  output logic [fcpf_pkg::PROB_W-1:0]           raw_prob,
  output logic [fcpf_pkg::PROB_W-1:0]           smoothed_prob,
  input  logic                                  cfg_write,
  input  logic [fcpf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fcpf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int FW = fcpf_pkg::FORCE_W;
  localparam int PW = fcpf_pkg::PROB_W;
  localparam int SW = fcpf_pkg::SQ_W;

  logic [FW-1:0] lo_limit;
  logic [FW-1:0] hi_limit;
  logic [PW-1:0] p_low;
  logic [PW-1:0] p_high;

  logic [PW-1:0] leg_prob [fcpf_pkg::NUM_LEGS];

  logic [fcpf_pkg::LEG_W-1:0] leg_r;
  logic [FW-1:0] fx;
  logic [FW-1:0] fy;
  logic [FW-1:0] fz;
  logic [FW-1:0] ax;
  logic [FW-1:0] ay;
  logic [FW-1:0] az;
  logic [SW-1:0] prod;
  logic [SW-1:0] acc;
  logic [SW-1:0] sq_rem;
  logic [SW-1:0] sq_res;
  logic [SW-1:0] sq_bit;
  logic [fcpf_pkg::CNT_W-1:0] cnt;
  logic          down;
  logic [PW-1:0] diff;
  logic [FW-1:0] dlt;
  logic [FW-1:0] den;
  logic [FW-1:0] div_rem;
  logic [PW-1:0] quo;
  logic [PW-1:0] raw;

  logic [FW-1:0] mul_a;
  logic [FW-1:0] mul_b;
  logic [SW-1:0] mul_p;
  logic [SW:0]   sq_trial;
  logic          sq_ge;
  logic [FW:0]   div_trial;
  logic          div_ge;
  logic [FW-1:0] mag;
  logic          leg_ok;
  logic [PW:0]   sum;
  logic          emit_fire;

  assign mag       = sq_res[FW-1:0];
  assign sq_trial  = {1'b0, sq_res} + {1'b0, sq_bit};
  assign sq_ge     = {1'b0, sq_rem} >= sq_trial;
  assign div_trial = {div_rem, quo[PW-1]};
  assign div_ge    = div_trial >= {1'b0, den};
  assign leg_ok    = int'(leg_r) < fcpf_pkg::NUM_LEGS;
  assign sum       = {1'b0, raw} + {1'b0, leg_prob[leg_r]};
  assign emit_fire = (ctrl.op == fcpf_pkg::OP_EMIT) && !status.out_busy;

  always_comb begin
    status.no_in     = !in_valid;
    status.z_pos     = (fz != '0) && !fz[FW-1];
    status.loop_more = cnt != '0;
    status.m_lt_lo   = mag < lo_limit;
    status.m_ge_hi   = mag >= hi_limit;
    status.out_busy  = out_valid && out_stall;
  end

  always_comb begin
    unique case (ctrl.op)
      fcpf_pkg::OP_MUL_Y: begin
        mul_a = ay;
        mul_b = ay;
      end
      fcpf_pkg::OP_MUL_Z: begin
        mul_a = az;
        mul_b = az;
      end
      fcpf_pkg::OP_MUL_D: begin
        mul_a = FW'(diff);
        mul_b = dlt;
      end
      default: begin
        mul_a = ax;
        mul_b = ax;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      fcpf_pkg::OP_LOAD: begin
        if (in_valid) begin
          leg_r <= leg;
          fx    <= force_x;
          fy    <= force_y;
          fz    <= force_z;
        end
      end
      fcpf_pkg::OP_ABS: begin
        ax <= fx[FW-1] ? (~fx + 1'b1) : fx;
        ay <= fy[FW-1] ? (~fy + 1'b1) : fy;
        az <= fz[FW-1] ? (~fz + 1'b1) : fz;
      end
      fcpf_pkg::OP_MUL_X: begin
        prod <= mul_p;
      end
      fcpf_pkg::OP_MUL_Y: begin
        prod <= mul_p;
        acc  <= prod;
      end
      fcpf_pkg::OP_MUL_Z: begin
        prod <= mul_p;
        acc  <= acc + prod;
      end
      fcpf_pkg::OP_ADD_Z: begin
        acc <= acc + prod;
      end
      fcpf_pkg::OP_SQRT_INIT: begin
        sq_rem <= acc;
        sq_res <= '0;
        sq_bit <= fcpf_pkg::SQRT_BIT_INIT;
        cnt    <= fcpf_pkg::SQRT_LAST;
      end
      fcpf_pkg::OP_SQRT_ITER: begin
        if (sq_ge) begin
          sq_rem <= sq_rem - sq_trial[SW-1:0];
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        cnt    <= cnt - 1'b1;
      end
      fcpf_pkg::OP_INTERP_SETUP: begin
        down <= p_high < p_low;
        diff <= (p_high < p_low) ? (p_low - p_high) : (p_high - p_low);
        dlt  <= mag - lo_limit;
        den  <= hi_limit - lo_limit;
      end
      fcpf_pkg::OP_MUL_D: begin
        prod <= mul_p;
      end
      fcpf_pkg::OP_DIV_INIT: begin
        div_rem <= prod[PW+FW-1:PW];
        quo     <= prod[PW-1:0];
        cnt     <= fcpf_pkg::DIV_LAST;
      end
      fcpf_pkg::OP_DIV_ITER: begin
        div_rem <= div_ge ? FW'(div_trial - {1'b0, den}) : div_trial[FW-1:0];
        quo     <= {quo[PW-2:0], div_ge};
        cnt     <= cnt - 1'b1;
      end
      fcpf_pkg::OP_RAW_INTERP: begin
        raw <= down ? (p_low - quo) : (p_low + quo);
      end
      fcpf_pkg::OP_RAW_LOW: begin
        raw <= p_low;
      end
      fcpf_pkg::OP_RAW_HIGH: begin
        raw <= p_high;
      end
      fcpf_pkg::OP_EMIT: begin
        if (emit_fire) begin
          leg_out       <= leg_r;
          raw_prob      <= raw;
          smoothed_prob <= leg_ok ? sum[PW:1] : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fcpf_pkg::NUM_LEGS; i++) begin
        leg_prob[i] <= '0;
      end
    end else if (emit_fire && leg_ok) begin
      leg_prob[leg_r] <= sum[PW:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_limit <= fcpf_pkg::RESET_FORCE_LOW_LIMIT;
      hi_limit <= fcpf_pkg::RESET_FORCE_HIGH_LIMIT;
      p_low    <= fcpf_pkg::RESET_PROB_LOW;
      p_high   <= fcpf_pkg::RESET_PROB_HIGH;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fcpf_pkg::REG_FORCE_LOW_LIMIT:  lo_limit <= cfg_data[FW-1:0];
        fcpf_pkg::REG_FORCE_HIGH_LIMIT: hi_limit <= cfg_data[FW-1:0];
        fcpf_pkg::REG_PROB_LOW:         p_low    <= cfg_data[PW-1:0];
        fcpf_pkg::REG_PROB_HIGH:        p_high   <= cfg_data[PW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/foot_contact_probability_filter_top.sv
// ----------------------------------------------------------------------------
// foot_contact_probability_filter_top: foot contact probability filter
// Turns one foot force sample into a raw contact probability and folds it
// into the smoothed probability of its leg.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------
//  input    | in_valid / in_stall    | leg, force_x, force_y, force_z
//  output   | out_valid / out_stall  | leg_out, raw_prob, smoothed_prob
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request at a time: a new sample is accepted only once the current one
// is through. An interpolated sample runs the 20 square root steps and 16
// divider steps; a sample at or above the upper limit, below the lower limit
// or with a positive vertical force skips the interpolation.
// Reset clears the leg probabilities, loads the default limits and holds the
// request channel stalled.
// A stalled result holds in the output register; the program waits there.
module foot_contact_probability_filter_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [fcpf_pkg::LEG_W-1:0]            leg,
  input  logic signed [fcpf_pkg::FORCE_W-1:0]   force_x,
  input  logic signed [fcpf_pkg::FORCE_W-1:0]   force_y,
  input  logic signed [fcpf_pkg::FORCE_W-1:0]   force_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [fcpf_pkg::LEG_W-1:0]            leg_out,
  output logic [fcpf_pkg::PROB_W-1:0]           raw_prob,
  output logic [fcpf_pkg::PROB_W-1:0]           smoothed_prob,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fcpf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fcpf_pkg::CFG_DATA_W-1:0]       cfg_data
);

  fcpf_pkg::ucode_t  ctrl;
  fcpf_pkg::status_t status;

  assign in_stall  = rst || (ctrl.op != fcpf_pkg::OP_LOAD);
  assign cfg_ready = 1'b1;

  fcpf_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  fcpf_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .status        (status),
    .in_valid      (in_valid),
    .leg           (leg),
    .force_x       (force_x),
    .force_y       (force_y),
    .force_z       (force_z),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .leg_out       (leg_out),
    .raw_prob      (raw_prob),
    .smoothed_prob (smoothed_prob),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("input taken while a request was still in work");

  a_result_while_busy: assert property (
    @(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_stall
  ) else $error("result appeared without a request in work");

  a_result_needs_request: assert property (
    @(posedge clk) disable iff (rst)
    (!in_stall && !out_valid) |=> !out_valid
  ) else $error("result appeared while the program was idle");

endmodule
